/* rtl/crr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crr_pkg: shared types and helpers for the channel routing block
// Holds the register indexes, cell kind codes, the queued item type and the
// small helpers for D8 decoding, grid clamping and 48-bit saturation.
// ----------------------------------------------------------------------------
package crr_pkg;

    // Default grid limits, used by the top level parameters.
    localparam int DEF_MAX_ROWS = 64;
    localparam int DEF_MAX_COLS = 64;

    // Configuration port geometry.
    localparam int CFG_AW = 3;
    localparam int CFG_DW = 32;

    // Register indexes.
    typedef enum logic [CFG_AW-1:0] {
        REG_NUM_COLS     = 3'd0,
        REG_NUM_ROWS     = 3'd1,
        REG_DECAY_FACTOR = 3'd2,
        REG_STORAGE_GAIN = 3'd3,
        REG_RECIP_STEP   = 3'd4
    } reg_idx_t;

    // Commands and codes.
    localparam logic       CMD_LOAD       = 1'b0;
    localparam logic       CMD_ROUTE      = 1'b1;
    localparam logic [1:0] KIND_NONE      = 2'd0;
    localparam logic [1:0] KIND_LAND      = 2'd1;
    localparam logic [1:0] KIND_CHANNEL   = 2'd2;
    localparam logic [1:0] KIND_UNUSED    = 2'd3;
    localparam logic       STATUS_OK      = 1'b0;
    localparam logic       STATUS_BAD_DIR = 1'b1;

    typedef logic signed [47:0] flow_t;
    typedef logic signed [48:0] wide_t;

    localparam flow_t POS48 = {1'b0, {47{1'b1}}};
    localparam flow_t NEG48 = {1'b1, {47{1'b0}}};

    // One classified request as it waits between front and back.
    typedef struct packed {
        logic       cmd;
        logic [5:0] row;
        logic [5:0] col;
        logic [1:0] kind;
        logic [2:0] dir_idx;
        logic       status;
        logic       in_grid;
        flow_t      lateral;
        logic       last;
    } crr_item_t;

    // Clamp a grid dimension register to 1..hi.
    function automatic int clamp_dim(logic [6:0] v, int hi);
        int x;
        x = int'(v);
        if (x < 1) return 1;
        if (x > hi) return hi;
        return x;
    endfunction

    // D8 code to index; bit 3 set when the code has exactly one bit set.
    function automatic logic [3:0] d8_decode(logic [7:0] code);
        logic [3:0] r;
        r = 4'd0;
        for (int i = 0; i < 8; i++) begin
            if (code == 8'(1 << i)) r = {1'b1, 3'(i)};
        end
        return r;
    endfunction

    function automatic logic signed [1:0] d8_drow(logic [2:0] d);
        logic signed [1:0] r;
        unique case (d)
            3'd0, 3'd4: r = 2'sd0;
            3'd1, 3'd2, 3'd3: r = 2'sd1;
            default: r = -2'sd1;
        endcase
        return r;
    endfunction

    function automatic logic signed [1:0] d8_dcol(logic [2:0] d);
        logic signed [1:0] r;
        unique case (d)
            3'd2, 3'd6: r = 2'sd0;
            3'd0, 3'd1, 3'd7: r = 2'sd1;
            default: r = -2'sd1;
        endcase
        return r;
    endfunction

    // Clamp a 49-bit signed value to 48 bits.
    function automatic flow_t sat49(wide_t v);
        if (v[48] != v[47]) return v[48] ? NEG48 : POS48;
        return flow_t'(v[47:0]);
    endfunction

    function automatic wide_t ext49(flow_t v);
        return {v[47], v};
    endfunction

endpackage

/* rtl/crr_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crr_ram: generic single-write, single-read memory
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module crr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write, then registered read.
    always_ff @(posedge aclk) begin
        if (we) mem_reg[waddr] <= wdata;
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/crr_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crr_front: request intake and classification
// Unpacks each request, checks it against the grid in use, decodes the D8
// code, forms the raster index and holds it in a two-entry queue.
// ----------------------------------------------------------------------------
module crr_front #(
    parameter int MAX_ROWS = crr_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = crr_pkg::DEF_MAX_COLS,
    parameter int CW       = 12
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [71:0]         s_tdata,
    input  logic                s_tuser,
    input  logic                s_tlast,
    input  logic [6:0]          num_cols,
    input  logic [6:0]          num_rows,
    input  logic                hold,
    output logic                deq_valid,
    input  logic                deq_ready,
    output crr_pkg::crr_item_t  deq_item,
    output logic [CW-1:0]       deq_cell
);
    import crr_pkg::*;

    crr_item_t   item;
    logic [CW-1:0] cell_idx;
    logic [3:0]  dec;
    logic [1:0]  kind_in;
    int          cols_c;
    int          rows_c;

    crr_item_t     item_q_reg [2];
    logic [CW-1:0] cell_q_reg [2];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    count_reg;
    logic          push;
    logic          pop;

    // Classify the incoming request.
    always_comb begin
        cols_c  = clamp_dim(num_cols, MAX_COLS);
        rows_c  = clamp_dim(num_rows, MAX_ROWS);
        dec     = d8_decode(s_tdata[21:14]);
        kind_in = s_tdata[13:12];
        item.cmd     = s_tuser;
        item.row     = s_tdata[5:0];
        item.col     = s_tdata[11:6];
        item.lateral = flow_t'(s_tdata[69:22]);
        item.last    = s_tlast;
        item.dir_idx = dec[2:0];
        item.in_grid = (int'(item.row) < rows_c) && (int'(item.col) < cols_c);
        item.status  = STATUS_OK;
        item.kind    = (kind_in == KIND_UNUSED) ? KIND_NONE : kind_in;
        if (item.kind == KIND_CHANNEL && !dec[3]) begin
            item.kind = KIND_LAND;
            if (item.in_grid && item.cmd == CMD_LOAD) item.status = STATUS_BAD_DIR;
        end
        cell_idx = CW'(int'(item.row) * cols_c + int'(item.col));
    end

    assign s_tready  = (count_reg != 2'd2) && !hold;
    assign push      = s_tvalid && s_tready;
    assign deq_valid = (count_reg != 2'd0);
    assign pop       = deq_valid && deq_ready;
    assign deq_item  = item_q_reg[rd_ptr_reg];
    assign deq_cell  = cell_q_reg[rd_ptr_reg];

    // Queue storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            item_q_reg[wr_ptr_reg] <= item;
            cell_q_reg[wr_ptr_reg] <= cell_idx;
        end
    end

    // Queue pointers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop) rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

/* rtl/crr_mul.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crr_mul: signed by unsigned fixed-point multiplier
// Three-stage pipeline: low and high partial products on 32-bit slices,
// then Q16 rounding half away from zero and 48-bit saturation.
// ----------------------------------------------------------------------------
module crr_mul (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  crr_pkg::wide_t      a,
    input  logic [31:0]         b,
    output logic                done,
    output crr_pkg::flow_t      res
);
    import crr_pkg::*;

    logic [48:0] mag;
    logic [63:0] plo_reg;
    logic [63:0] plo2_reg;
    logic [16:0] mhi_reg;
    logic [31:0] b_reg;
    logic [48:0] phi_reg;
    logic        neg_reg;
    logic        neg2_reg;
    logic        v1_reg;
    logic        v2_reg;
    logic        v3_reg;
    flow_t       res_reg;
    logic [64:0] rnd;
    logic [65:0] sum;
    flow_t       res_next;

    assign mag = a[48] ? 49'(-a) : 49'(a);

    // Stage one: low slice product; stage two: high slice product.
    always_ff @(posedge aclk) begin
        plo_reg  <= mag[31:0] * b;
        mhi_reg  <= mag[48:32];
        b_reg    <= b;
        neg_reg  <= a[48];
        phi_reg  <= 49'(mhi_reg) * 49'(b_reg);
        plo2_reg <= plo_reg;
        neg2_reg <= neg_reg;
        res_reg  <= res_next;
    end

    // Stage three: round, combine and saturate.
    always_comb begin
        rnd = {1'b0, plo2_reg} + 65'h8000;
        sum = 66'(rnd[64:16]) + 66'({phi_reg[31:0], 16'd0});
        if (phi_reg[48:32] != 17'd0) begin
            res_next = neg2_reg ? NEG48 : POS48;
        end else if (neg2_reg) begin
            res_next = (sum > 66'h8000_0000_0000) ? NEG48 : flow_t'(~sum[47:0] + 48'd1);
        end else begin
            res_next = (sum > 66'(POS48)) ? POS48 : flow_t'(sum[47:0]);
        end
    end

    // Stage valids.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= start;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    assign done = v3_reg;
    assign res  = res_reg;

endmodule

/* rtl/crr_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crr_back: cell stores and reservoir update sequencer
// Holds the kind, direction, volume and inflow bank memories, clears all but
// the direction store after reset, and runs each channel route through the
// shared multiplier.
module crr_back #(
    parameter int MAX_ROWS = crr_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = crr_pkg::DEF_MAX_COLS,
    parameter int CELLS    = 4096,
    parameter int CW       = 12
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [6:0]          num_cols,
    input  logic [6:0]          num_rows,
    input  logic [15:0]         decay_factor,
    input  logic [31:0]         storage_gain,
    input  logic [16:0]         recip_step,
    input  logic                deq_valid,
    output logic                deq_ready,
    input  crr_pkg::crr_item_t  deq_item,
    input  logic [CW-1:0]       deq_cell,
    output logic                clr_busy,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [95:0]         m_tdata,
    output logic [1:0]          m_tuser
);
    import crr_pkg::*;

    typedef enum logic [8:0] {
        S_CLR  = 9'b000000001,
        S_IDLE = 9'b000000010,
        S_RD   = 9'b000000100,
        S_MULA = 9'b000001000,
        S_MULB = 9'b000010000,
        S_MV   = 9'b000100000,
        S_MULC = 9'b001000000,
        S_DNWR = 9'b010000000,
        S_OUT  = 9'b100000000
    } state_t;

    state_t        state_reg, state_next;
    logic [CW-1:0] clr_cnt_reg;
    logic          bank_sel_reg;
    crr_item_t     item_reg;
    logic [CW-1:0] cell_reg;
    flow_t         vold_reg, q_reg, a_reg, vol_reg, qout_reg;
    logic [2:0]    dir_reg;
    logic [CW-1:0] dn_reg;
    logic          dn_ok_reg;
    logic          status_reg, chan_reg;

    logic          load_wr;
    int            cols_c, rows_c, nr_i, nc_i;

    // Memory ports.
    logic          kind_we, dir_we, vol_we;
    logic [CW-1:0] kind_wa, vol_wa;
    logic [1:0]    kind_wd, kind_rd;
    logic [2:0]    dir_rd;
    flow_t         vol_wd, vol_rd;
    logic          bank_we [2];
    logic [CW-1:0] bank_wa [2];
    logic [CW-1:0] bank_ra [2];
    flow_t         bank_wd [2];
    flow_t         bank_rd [2];
    flow_t         inflow_rd;

    // Multiplier hookup.
    logic          mul_start, mul_done;
    wide_t         mul_a;
    logic [31:0]   mul_b;
    flow_t         mul_res;

    assign cols_c    = clamp_dim(num_cols, MAX_COLS);
    assign rows_c    = clamp_dim(num_rows, MAX_ROWS);
    assign load_wr   = (state_reg == S_IDLE) && deq_valid && deq_item.in_grid
                       && (deq_item.cmd == CMD_LOAD);
    assign inflow_rd = bank_rd[bank_sel_reg];
    assign deq_ready = (state_reg == S_IDLE);
    assign clr_busy  = (state_reg == S_CLR);

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLR:  if (clr_cnt_reg == CW'(CELLS - 1)) state_next = S_IDLE;
            S_IDLE: begin
                if (deq_valid) begin
                    state_next = (deq_item.in_grid && deq_item.cmd == CMD_ROUTE)
                                 ? S_RD : S_OUT;
                end
            end
            S_RD:   state_next = (kind_rd == KIND_CHANNEL) ? S_MULA : S_OUT;
            S_MULA: if (mul_done) state_next = S_MULB;
            S_MULB: if (mul_done) state_next = S_MV;
            S_MV:   state_next = S_MULC;
            S_MULC: if (mul_done) state_next = S_DNWR;
            S_DNWR: state_next = S_OUT;
            S_OUT:  if (m_tready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Multiplier operand selection.
    always_comb begin
        mul_start = 1'b0;
        mul_a     = ext49(vol_rd);
        mul_b     = {16'd0, decay_factor};
        unique case (state_reg)
            S_RD:   mul_start = (kind_rd == KIND_CHANNEL);
            S_MULA: begin
                mul_start = mul_done;
                mul_a     = ext49(q_reg);
                mul_b     = storage_gain;
            end
            S_MV:   begin
                mul_start = 1'b1;
                mul_a     = ext49(vol_reg) - ext49(vold_reg);
                mul_b     = {15'd0, recip_step};
            end
            default: mul_start = 1'b0;
        endcase
    end

    // Memory write and read control.
    always_comb begin
        kind_we = clr_busy || load_wr;
        kind_wa = clr_busy ? clr_cnt_reg : deq_cell;
        kind_wd = clr_busy ? KIND_NONE : deq_item.kind;
        dir_we  = load_wr && (deq_item.kind == KIND_CHANNEL);
        vol_we  = clr_busy || load_wr || (state_reg == S_DNWR);
        vol_wa  = clr_busy ? clr_cnt_reg : ((state_reg == S_DNWR) ? cell_reg : deq_cell);
        vol_wd  = (state_reg == S_DNWR) ? vol_reg : '0;
        for (int i = 0; i < 2; i++) begin
            bank_ra[i] = (1'(i) == bank_sel_reg) ? deq_cell : dn_reg;
            bank_we[i] = clr_busy || load_wr
                         || ((state_reg == S_RD) && (1'(i) == bank_sel_reg))
                         || ((state_reg == S_DNWR) && dn_ok_reg && (1'(i) != bank_sel_reg));
            bank_wa[i] = deq_cell;
            bank_wd[i] = '0;
            if (clr_busy) begin
                bank_wa[i] = clr_cnt_reg;
            end else if (state_reg == S_RD) begin
                bank_wa[i] = cell_reg;
            end else if (state_reg == S_DNWR) begin
                bank_wa[i] = dn_reg;
                bank_wd[i] = sat49(ext49(bank_rd[i]) + ext49(qout_reg));
            end
        end
    end

    // Downstream neighbor of the current cell.
    always_comb begin
        nr_i = int'(item_reg.row) + int'(d8_drow(dir_reg));
        nc_i = int'(item_reg.col) + int'(d8_dcol(dir_reg));
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            S_IDLE: begin
                if (deq_valid) begin
                    item_reg   <= deq_item;
                    cell_reg   <= deq_cell;
                    status_reg <= deq_item.status;
                    chan_reg   <= load_wr && (deq_item.kind == KIND_CHANNEL);
                    qout_reg   <= '0;
                    vol_reg    <= '0;
                end
            end
            S_RD: begin
                vold_reg <= vol_rd;
                dir_reg  <= dir_rd;
                q_reg    <= sat49(ext49(inflow_rd) + ext49(item_reg.lateral));
                chan_reg <= (kind_rd == KIND_CHANNEL);
            end
            S_MULA: if (mul_done) a_reg <= mul_res;
            S_MULB: if (mul_done) vol_reg <= sat49(ext49(a_reg) + ext49(mul_res));
            S_MV: begin
                dn_ok_reg <= (nr_i >= 0) && (nc_i >= 0) && (nr_i < rows_c) && (nc_i < cols_c);
                dn_reg    <= CW'(nr_i * cols_c + nc_i);
            end
            S_MULC: if (mul_done) qout_reg <= sat49(ext49(q_reg) - ext49(mul_res));
            default: ;
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLR;
            clr_cnt_reg  <= '0;
            bank_sel_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (clr_busy) clr_cnt_reg <= clr_cnt_reg + CW'(1);
            if ((state_reg == S_OUT) && m_tready && (item_reg.cmd == CMD_ROUTE)
                && item_reg.last) begin
                bank_sel_reg <= ~bank_sel_reg;
            end
        end
    end

    // Cell stores.
    crr_ram #(.WIDTH(2), .DEPTH(CELLS)) u_kind (
        .aclk(aclk), .we(kind_we), .waddr(kind_wa), .wdata(kind_wd),
        .raddr(deq_cell), .rdata(kind_rd)
    );

    crr_ram #(.WIDTH(3), .DEPTH(CELLS)) u_dir (
        .aclk(aclk), .we(dir_we), .waddr(deq_cell), .wdata(deq_item.dir_idx),
        .raddr(deq_cell), .rdata(dir_rd)
    );

    crr_ram #(.WIDTH(48), .DEPTH(CELLS)) u_vol (
        .aclk(aclk), .we(vol_we), .waddr(vol_wa), .wdata(vol_wd),
        .raddr(deq_cell), .rdata(vol_rd)
    );

    // Inflow accumulator banks, one memory per bank.
    for (genvar g = 0; g < 2; g++) begin : g_bank
        crr_ram #(.WIDTH(48), .DEPTH(CELLS)) u_bank (
            .aclk(aclk), .we(bank_we[g]), .waddr(bank_wa[g]), .wdata(bank_wd[g]),
            .raddr(bank_ra[g]), .rdata(bank_rd[g])
        );
    end

    crr_mul u_mul (
        .aclk(aclk), .aresetn(aresetn), .start(mul_start), .a(mul_a), .b(mul_b),
        .done(mul_done), .res(mul_res)
    );

    // Result register.
    assign m_tvalid = (state_reg == S_OUT);
    assign m_tdata  = {vol_reg, qout_reg};
    assign m_tuser  = {chan_reg, status_reg};

endmodule

/* rtl/channel_network_reservoir_routing.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// channel_network_reservoir_routing: linear-reservoir routing on a D8 grid
// A load or off-grid request goes from the queue straight to the result; a
// route of a cell that is not a channel reach first reads the stores; and a
// channel route also makes three passes through the 3-stage shared multiplier
// and a downstream accumulate. A new request starts only after the last
// result is taken, while the front queue holds up to two waiting requests.
// Reset: after aresetn all stores but direction clear their MAX_ROWS*MAX_COLS
// entries (4096 by default) with s_tready low; configuration writes are taken.
// ----------------------------------------------------------------------------
module channel_network_reservoir_routing #(
    parameter int MAX_ROWS = crr_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = crr_pkg::DEF_MAX_COLS
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // Request channel.
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // row, col, cell_kind, flow_dir, lateral_inflow, zero fill
    input  logic [71:0]                 s_tdata,
    // cmd
    input  logic                        s_tuser,
    // last_cell
    input  logic                        s_tlast,
    // Result channel.
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // outflow, volume
    output logic [95:0]                 m_tdata,
    // status, is_channel
    output logic [1:0]                  m_tuser,
    // Configuration write port.
    input  logic                        cfg_wr_en,
    input  logic [crr_pkg::CFG_AW-1:0]  cfg_addr,
    input  logic [crr_pkg::CFG_DW-1:0]  cfg_wdata
);
    import crr_pkg::*;

    localparam int CELLS = MAX_ROWS * MAX_COLS;
    localparam int CW    = (CELLS > 1) ? $clog2(CELLS) : 1;

    logic [6:0]    num_cols_reg, num_rows_reg;
    logic [15:0]   decay_factor_reg;
    logic [31:0]   storage_gain_reg;
    logic [16:0]   recip_step_reg;

    logic          deq_valid, deq_ready, clr_busy;
    crr_item_t     deq_item;
    logic [CW-1:0] deq_cell;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_cols_reg     <= 7'd64;
            num_rows_reg     <= 7'd64;
            decay_factor_reg <= 16'd0;
            storage_gain_reg <= 32'd0;
            recip_step_reg   <= 17'h10000;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_NUM_COLS:     num_cols_reg     <= cfg_wdata[6:0];
                REG_NUM_ROWS:     num_rows_reg     <= cfg_wdata[6:0];
                REG_DECAY_FACTOR: decay_factor_reg <= cfg_wdata[15:0];
                REG_STORAGE_GAIN: storage_gain_reg <= cfg_wdata;
                REG_RECIP_STEP:   recip_step_reg   <= cfg_wdata[16:0];
                default: ;
            endcase
        end
    end

    crr_front #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS), .CW(CW)) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .num_cols(num_cols_reg), .num_rows(num_rows_reg), .hold(clr_busy),
        .deq_valid(deq_valid), .deq_ready(deq_ready),
        .deq_item(deq_item), .deq_cell(deq_cell)
    );

    crr_back #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS), .CELLS(CELLS), .CW(CW)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .num_cols(num_cols_reg), .num_rows(num_rows_reg),
        .decay_factor(decay_factor_reg), .storage_gain(storage_gain_reg),
        .recip_step(recip_step_reg),
        .deq_valid(deq_valid), .deq_ready(deq_ready),
        .deq_item(deq_item), .deq_cell(deq_cell), .clr_busy(clr_busy),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

endmodule
